// File: rtl/sfcs_pkg.sv
package sfcs_pkg;

  localparam int unsigned RESULTS_MAX = 6;
  localparam int unsigned CNT_W       = 3;

  localparam logic [3:0] OP_READ    = 4'd0;
  localparam logic [3:0] OP_PROG    = 4'd1;
  localparam logic [3:0] OP_ER4K    = 4'd2;
  localparam logic [3:0] OP_ER64K   = 4'd3;
  localparam logic [3:0] OP_CHIP    = 4'd4;
  localparam logic [3:0] OP_STAT1   = 4'd5;
  localparam logic [3:0] OP_STAT2   = 4'd6;
  localparam logic [3:0] OP_SLEEP   = 4'd7;
  localparam logic [3:0] OP_RESUME  = 4'd8;
  localparam logic [3:0] OP_WRSTAT  = 4'd9;
  localparam logic [3:0] OP_WRDIS   = 4'd10;
  localparam logic [3:0] OP_VOLSTAT = 4'd11;
  localparam logic [3:0] OP_RX      = 4'd12;

  localparam logic [7:0] CMD_RDSR1  = 8'h05;
  localparam logic [7:0] CMD_RDSR2  = 8'h35;
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_CHIP   = 8'hC7;
  localparam logic [7:0] CMD_ER4K   = 8'h20;
  localparam logic [7:0] CMD_ER64K  = 8'hD8;
  localparam logic [7:0] CMD_PROG   = 8'h02;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_WRDI   = 8'h04;
  localparam logic [7:0] CMD_WRSR   = 8'h01;
  localparam logic [7:0] CMD_SLEEP  = 8'hB9;
  localparam logic [7:0] CMD_RESUME = 8'hAB;
  localparam logic [7:0] CMD_VOLSR  = 8'h50;
  localparam logic [7:0] NO_SECOND  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_SLOT   = 2'd1,
    KIND_ANSWER = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_READY      = 8'b0000_0010,
    PH_WEL        = 8'b0000_0100,
    PH_DATA       = 8'b0000_1000,
    PH_STATUS     = 8'b0001_0000,
    PH_POLL       = 8'b0010_0000,
    PH_WRSTAT_WEL = 8'b0100_0000,
    PH_WRDIS_WEL  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [23:0] address;
    logic [7:0]  payload;
    logic [7:0]  second_status;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        release_select;
    logic        answer_ok;
    logic [7:0]  answer_data;
    logic        last;
  } rsp_t;

endpackage

// File: rtl/spi_flash_command_sequencer_unit.sv
// The first result is registered and shown in the cycle after the request transfer.
// Throughput: one result per cycle while rsp_stall is low; a request emitting
// N results (0 to 6) holds the result buffer until they have all left, and the next
// request is taken in the cycle its last result leaves. Set by the single shifting result buffer.
// Reset: synchronous; idle phase, held status byte all ones, buffer empty.
module spi_flash_command_sequencer_unit #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sfcs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sfcs_pkg::rsp_t rsp
);
  import sfcs_pkg::*;

  localparam int unsigned AddrBytes = (ADDRESS_BITS + 7) / 8;
  localparam int unsigned AddrExtW  = AddrBytes * 8;

  phase_t                  phase, phase_next;
  logic [3:0]              pending_request, pending_request_next;
  logic [ADDRESS_BITS-1:0] held_address;
  logic [7:0]              held_payload;
  logic [7:0]              held_second_status;

  rsp_t                    seq_q [RESULTS_MAX];
  logic [CNT_W-1:0]        count_q;
  rsp_t                    seq [RESULTS_MAX];
  logic [CNT_W-1:0]        cnt;

  logic                    accept;
  logic                    rsp_xfer;
  logic                    is_request;
  logic [AddrExtW-1:0]     addr_ext;
  logic [7:0]              rx_b;

  function automatic rsp_t f_send(input logic [7:0] b, input logic rel);
    rsp_t r;
    r = '0;
    r.kind = KIND_SEND;
    r.tx_byte = b;
    r.release_select = rel;
    return r;
  endfunction

  function automatic rsp_t f_slot();
    rsp_t r;
    r = '0;
    r.kind = KIND_SLOT;
    r.release_select = 1'b1;
    return r;
  endfunction

  function automatic rsp_t f_answer(input logic ok, input logic [7:0] data);
    rsp_t r;
    r = '0;
    r.kind = KIND_ANSWER;
    r.answer_ok = ok;
    r.answer_data = data;
    return r;
  endfunction

  assign rsp_valid  = (count_q != '0);
  assign rsp        = seq_q[0];
  assign rsp_xfer   = rsp_valid && !rsp_stall;
  assign req_stall  = (count_q != '0) && !((count_q == CNT_W'(1)) && !rsp_stall);
  assign accept     = req_valid && !req_stall;
  assign is_request = (req.operation < OP_RX) && (phase == PH_IDLE);
  assign addr_ext   = AddrExtW'(held_address);
  assign rx_b       = req.payload;

  always_comb begin
    for (int k = 0; k < RESULTS_MAX; k++) begin
      seq[k] = '0;
    end
    cnt = '0;
    phase_next = phase;
    pending_request_next = pending_request;

    if (accept && req.operation == OP_RX) begin
      case (phase)
        PH_READY: begin
          if (rx_b[0]) begin
            seq[cnt] = f_answer(1'b0, 8'h00); cnt = cnt + 1'b1;
            phase_next = PH_IDLE;
          end else if (pending_request == OP_READ) begin
            seq[cnt] = f_send(CMD_READ, 1'b0); cnt = cnt + 1'b1;
            for (int i = AddrBytes - 1; i >= 0; i--) begin
              seq[cnt] = f_send(addr_ext[8*i +: 8], 1'b0); cnt = cnt + 1'b1;
            end
            seq[cnt] = f_slot(); cnt = cnt + 1'b1;
            phase_next = PH_DATA;
          end else begin
            seq[cnt] = f_send(CMD_WREN, 1'b1); cnt = cnt + 1'b1;
            seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
            seq[cnt] = f_slot(); cnt = cnt + 1'b1;
            phase_next = PH_WEL;
          end
        end
        PH_WEL: begin
          if (!rx_b[1]) begin
            seq[cnt] = f_answer(1'b0, 8'h00); cnt = cnt + 1'b1;
            phase_next = PH_IDLE;
          end else begin
            case (pending_request)
              OP_PROG: begin
                seq[cnt] = f_send(CMD_PROG, 1'b0); cnt = cnt + 1'b1;
                for (int i = AddrBytes - 1; i >= 0; i--) begin
                  seq[cnt] = f_send(addr_ext[8*i +: 8], 1'b0); cnt = cnt + 1'b1;
                end
                seq[cnt] = f_send(held_payload, 1'b1); cnt = cnt + 1'b1;
                seq[cnt] = f_answer(1'b1, 8'h00); cnt = cnt + 1'b1;
                phase_next = PH_IDLE;
              end
              OP_ER4K, OP_ER64K: begin
                seq[cnt] = f_send((pending_request == OP_ER4K) ? CMD_ER4K : CMD_ER64K,
                                  1'b0);
                cnt = cnt + 1'b1;
                for (int i = AddrBytes - 1; i >= 0; i--) begin
                  seq[cnt] = f_send(addr_ext[8*i +: 8], (i == 0));
                  cnt = cnt + 1'b1;
                end
                seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
                seq[cnt] = f_slot(); cnt = cnt + 1'b1;
                phase_next = PH_POLL;
              end
              OP_CHIP: begin
                seq[cnt] = f_send(CMD_CHIP, 1'b1); cnt = cnt + 1'b1;
                seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
                seq[cnt] = f_slot(); cnt = cnt + 1'b1;
                phase_next = PH_POLL;
              end
              default: begin
                seq[cnt] = f_send(CMD_SLEEP, 1'b1); cnt = cnt + 1'b1;
                seq[cnt] = f_answer(1'b1, 8'h00); cnt = cnt + 1'b1;
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
        PH_DATA, PH_STATUS: begin
          seq[cnt] = f_answer(1'b1, rx_b); cnt = cnt + 1'b1;
          phase_next = PH_IDLE;
        end
        PH_POLL: begin
          if (rx_b[0]) begin
            seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
            seq[cnt] = f_slot(); cnt = cnt + 1'b1;
          end else begin
            seq[cnt] = f_answer(1'b1, 8'h00); cnt = cnt + 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_WRSTAT_WEL: begin
          seq[cnt] = f_send(CMD_WRSR, 1'b0); cnt = cnt + 1'b1;
          seq[cnt] = f_send(held_payload, held_second_status == NO_SECOND);
          cnt = cnt + 1'b1;
          if (held_second_status != NO_SECOND) begin
            seq[cnt] = f_send(held_second_status, 1'b1); cnt = cnt + 1'b1;
          end
          seq[cnt] = f_answer(1'b1, 8'h00); cnt = cnt + 1'b1;
          phase_next = PH_IDLE;
        end
        PH_WRDIS_WEL: begin
          seq[cnt] = f_answer(!rx_b[1], 8'h00); cnt = cnt + 1'b1;
          phase_next = PH_IDLE;
        end
        default: ;
      endcase
    end else if (accept && is_request) begin
      pending_request_next = req.operation;
      case (req.operation)
        OP_READ, OP_PROG, OP_ER4K, OP_ER64K, OP_CHIP, OP_SLEEP: begin
          seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
          seq[cnt] = f_slot(); cnt = cnt + 1'b1;
          phase_next = PH_READY;
        end
        OP_STAT1, OP_STAT2: begin
          seq[cnt] = f_send((req.operation == OP_STAT1) ? CMD_RDSR1 : CMD_RDSR2, 1'b0);
          cnt = cnt + 1'b1;
          seq[cnt] = f_slot(); cnt = cnt + 1'b1;
          phase_next = PH_STATUS;
        end
        OP_RESUME: begin
          seq[cnt] = f_send(CMD_RESUME, 1'b1); cnt = cnt + 1'b1;
          seq[cnt] = f_answer(1'b1, 8'h00); cnt = cnt + 1'b1;
          phase_next = PH_IDLE;
        end
        OP_WRSTAT: begin
          seq[cnt] = f_send(CMD_WREN, 1'b1); cnt = cnt + 1'b1;
          seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
          seq[cnt] = f_slot(); cnt = cnt + 1'b1;
          phase_next = PH_WRSTAT_WEL;
        end
        OP_WRDIS: begin
          seq[cnt] = f_send(CMD_WRDI, 1'b1); cnt = cnt + 1'b1;
          seq[cnt] = f_send(CMD_RDSR1, 1'b0); cnt = cnt + 1'b1;
          seq[cnt] = f_slot(); cnt = cnt + 1'b1;
          phase_next = PH_WRDIS_WEL;
        end
        default: begin
          seq[cnt] = f_send(CMD_VOLSR, 1'b1); cnt = cnt + 1'b1;
          seq[cnt] = f_answer(1'b1, 8'h00); cnt = cnt + 1'b1;
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (cnt != '0) begin
      seq[cnt - 1'b1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      pending_request    <= OP_READ;
      held_address       <= '0;
      held_payload       <= '0;
      held_second_status <= NO_SECOND;
      count_q            <= '0;
    end else begin
      phase           <= phase_next;
      pending_request <= pending_request_next;
      if (accept && is_request) begin
        held_address       <= req.address[ADDRESS_BITS-1:0];
        held_payload       <= req.payload;
        held_second_status <= req.second_status;
      end
      if (accept && cnt != '0) begin
        count_q <= cnt;
      end else if (rsp_xfer) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cnt != '0) begin
      for (int k = 0; k < RESULTS_MAX; k++) begin
        seq_q[k] <= seq[k];
      end
    end else if (rsp_xfer) begin
      for (int k = 0; k < RESULTS_MAX - 1; k++) begin
        seq_q[k] <= seq_q[k+1];
      end
    end
  end

endmodule
